// File: design/vcbts_pkg.sv
// ----------------------------------------------------------------------------
// vcbts_pkg: shared types and constants of the view cone target selector
// Field widths, datapath widths, register map, sequencer states.
// ----------------------------------------------------------------------------
package vcbts_pkg;

  localparam int ID_BITS    = 16;
  localparam int POS_BITS   = 24;
  localparam int FWD_W      = 16;
  localparam int ALIGN_W    = 16;
  localparam int DIST_W     = 24;

  // offset from origin, one bit more than a coordinate
  localparam int DIFF_W     = POS_BITS + 1;
  // offsets that pass the range test fit in DIST_W magnitude bits
  localparam int MUL_W      = DIST_W + 1;
  localparam int PROD_W     = 2 * MUL_W;
  localparam int SQ_W       = 2 * DIST_W + 2;
  localparam int MAXSQ_W    = 2 * DIST_W;
  localparam int DOT_W      = FWD_W + DIST_W + 2;
  localparam int ADOT_W     = DOT_W - 1;
  localparam int REM_W      = DIST_W + 2;
  localparam int STEP_W     = DIST_W + 4;

  localparam int SQRT_STEPS = DIST_W;
  localparam int DIV_STEPS  = ALIGN_W - 1;
  localparam int MUL_STEPS  = 7;
  localparam int CNT_W      = $clog2(SQRT_STEPS + 1);

  localparam int TDATA_IN_W  = ((ID_BITS + 3 * POS_BITS + 7) / 8) * 8;
  localparam int TDATA_OUT_W = ((ID_BITS + ALIGN_W + DIST_W + 7) / 8) * 8;

  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 5;

  localparam logic signed [ALIGN_W-1:0] ALIGN_MAX = {1'b0, {(ALIGN_W-1){1'b1}}};
  localparam logic signed [ALIGN_W-1:0] ALIGN_MIN = {1'b1, {(ALIGN_W-1){1'b0}}};
  localparam logic signed [FWD_W-1:0]   FWD_X_RST = {1'b0, {(FWD_W-1){1'b1}}};

  typedef enum logic [2:0] {
    REG_ORIGIN_X  = 3'd0,
    REG_ORIGIN_Y  = 3'd1,
    REG_ORIGIN_Z  = 3'd2,
    REG_FORWARD_X = 3'd3,
    REG_FORWARD_Y = 3'd4,
    REG_FORWARD_Z = 3'd5,
    REG_MAX_DIST  = 3'd6,
    REG_MIN_ALIGN = 3'd7
  } reg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RANGE,
    ST_MUL,
    ST_CHECK,
    ST_SQRT,
    ST_DIVCHK,
    ST_DIV,
    ST_ALIGN,
    ST_DECIDE,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic in_ready;
    logic out_load;
    logic keep_upd;
  } ctl_t;

endpackage

// File: design/vcbts_sub_step.sv
// ----------------------------------------------------------------------------
// vcbts_sub_step: compare and subtract step
// One restoring step, shared by the square root and the division sequences.
// ----------------------------------------------------------------------------
module vcbts_sub_step import vcbts_pkg::*; (
  input  logic [STEP_W-1:0] cand_i,
  input  logic [STEP_W-1:0] sub_i,
  output logic              ge_o,
  output logic [STEP_W-1:0] diff_o
);

  logic [STEP_W:0] wide_diff;

  assign wide_diff = {1'b0, cand_i} - {1'b0, sub_i};
  // borrow out clear means the candidate covers the subtrahend
  assign ge_o      = ~wide_diff[STEP_W];
  assign diff_o    = ge_o ? wide_diff[STEP_W-1:0] : cand_i;

endmodule

// File: design/view_cone_best_target_select_unit.sv
// ----------------------------------------------------------------------------
// view_cone_best_target_select_unit: best aligned candidate in a view cone
// Streams candidate points, keeps the one closest in angle to the forward
// vector within range, and reports it on the last candidate of a scan.
// ----------------------------------------------------------------------------
//  channel   direction  transaction
//  s_axis    in         one candidate: id, x, y, z; tuser eligible; tlast ends scan
//  m_axis    out        one result per scan: id, cosine, distance; tuser found
//  apb       in         register writes and reads, 8 registers at 4*i
//
//  No candidate is accepted before the last one is done. An eligible one in
//  range takes 7 products on one 25x25 multiplier, 24 square root steps and
//  15 division steps on one shared compare and subtract unit; a saturated
//  cosine skips the division. An ineligible candidate goes straight to the
//  final state, one outside the range box leaves after the range test, and
//  one at zero distance or outside the range sphere after the products.
//  Reset clears configuration to defaults and the kept candidate.
//  A result waiting on m_axis holds the next last candidate in its final state.
// ----------------------------------------------------------------------------
module view_cone_best_target_select_unit import vcbts_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // tdata: cand_id[15:0], cand_x[39:16], cand_y[63:40], cand_z[87:64]
  input  logic [TDATA_IN_W-1:0]  s_axis_tdata,
  // tuser: is_eligible
  input  logic                   s_axis_tuser,
  input  logic                   s_axis_tlast,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // tdata: best_id[15:0], best_alignment[31:16], best_distance[55:32]
  output logic [TDATA_OUT_W-1:0] m_axis_tdata,
  // tuser: found
  output logic                   m_axis_tuser,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [CFG_ADDR_W-1:0]  paddr,
  input  logic [CFG_DATA_W-1:0]  pwdata,
  output logic [CFG_DATA_W-1:0]  prdata,
  output logic                   pready
);

  // configuration
  logic signed [POS_BITS-1:0] origin_x_q, origin_y_q, origin_z_q;
  logic signed [FWD_W-1:0]    fwd_x_q, fwd_y_q, fwd_z_q;
  logic [DIST_W-1:0]          max_dist_q;
  logic signed [ALIGN_W-1:0]  min_align_q;

  // sequencer
  state_e             state_q, state_d;
  ctl_t               ctl;
  logic [CNT_W-1:0]   cnt_q;
  logic               last_q;

  // datapath
  logic [ID_BITS-1:0]        id_q;
  logic signed [DIFF_W-1:0]  dx_q, dy_q, dz_q;
  logic signed [PROD_W-1:0]  prod_q;
  logic [SQ_W-1:0]           sq_q;
  logic signed [DOT_W-1:0]   dot_q;
  logic [MAXSQ_W-1:0]        maxsq_q;
  logic [ADOT_W-1:0]         adot_q;
  logic [MAXSQ_W-1:0]        sh_q;
  logic [REM_W-1:0]          rem_q;
  logic [DIST_W-1:0]         root_q;
  logic [DIV_STEPS-1:0]      num_q;
  logic signed [ALIGN_W-1:0] align_q;

  // kept candidate and output register
  logic                      have_best_q;
  logic [ID_BITS-1:0]        kept_id_q;
  logic signed [ALIGN_W-1:0] kept_align_q;
  logic [DIST_W-1:0]         kept_dist_q;
  logic                      m_valid_q;
  logic                      m_found_q;
  logic [ID_BITS-1:0]        m_id_q;
  logic signed [ALIGN_W-1:0] m_align_q;
  logic [DIST_W-1:0]         m_dist_q;

  // ---------------------------------------------------------------- APB
  logic     cfg_wr;
  reg_idx_e cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_e'(paddr[CFG_ADDR_W-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q  <= '0;
      origin_y_q  <= '0;
      origin_z_q  <= '0;
      fwd_x_q     <= FWD_X_RST;
      fwd_y_q     <= '0;
      fwd_z_q     <= '0;
      max_dist_q  <= '0;
      min_align_q <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_ORIGIN_X:  origin_x_q  <= pwdata[POS_BITS-1:0];
        REG_ORIGIN_Y:  origin_y_q  <= pwdata[POS_BITS-1:0];
        REG_ORIGIN_Z:  origin_z_q  <= pwdata[POS_BITS-1:0];
        REG_FORWARD_X: fwd_x_q     <= pwdata[FWD_W-1:0];
        REG_FORWARD_Y: fwd_y_q     <= pwdata[FWD_W-1:0];
        REG_FORWARD_Z: fwd_z_q     <= pwdata[FWD_W-1:0];
        REG_MAX_DIST:  max_dist_q  <= pwdata[DIST_W-1:0];
        REG_MIN_ALIGN: min_align_q <= pwdata[ALIGN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_ORIGIN_X:  prdata = CFG_DATA_W'($unsigned(origin_x_q));
      REG_ORIGIN_Y:  prdata = CFG_DATA_W'($unsigned(origin_y_q));
      REG_ORIGIN_Z:  prdata = CFG_DATA_W'($unsigned(origin_z_q));
      REG_FORWARD_X: prdata = CFG_DATA_W'($unsigned(fwd_x_q));
      REG_FORWARD_Y: prdata = CFG_DATA_W'($unsigned(fwd_y_q));
      REG_FORWARD_Z: prdata = CFG_DATA_W'($unsigned(fwd_z_q));
      REG_MAX_DIST:  prdata = CFG_DATA_W'(max_dist_q);
      REG_MIN_ALIGN: prdata = CFG_DATA_W'($unsigned(min_align_q));
      default:       prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- input
  logic                       in_acc;
  logic signed [POS_BITS-1:0] cand_x, cand_y, cand_z;
  logic                       go;

  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign cand_x = s_axis_tdata[ID_BITS +: POS_BITS];
  assign cand_y = s_axis_tdata[ID_BITS + POS_BITS +: POS_BITS];
  assign cand_z = s_axis_tdata[ID_BITS + 2*POS_BITS +: POS_BITS];
  assign go     = s_axis_tuser && (max_dist_q != '0) &&
                  ((fwd_x_q != '0) || (fwd_y_q != '0) || (fwd_z_q != '0));

  // ---------------------------------------------------------------- combinational datapath
  logic [DIFF_W-1:0] mag_x, mag_y, mag_z;
  logic              too_far;

  assign mag_x   = dx_q[DIFF_W-1] ? DIFF_W'(-dx_q) : DIFF_W'(dx_q);
  assign mag_y   = dy_q[DIFF_W-1] ? DIFF_W'(-dy_q) : DIFF_W'(dy_q);
  assign mag_z   = dz_q[DIFF_W-1] ? DIFF_W'(-dz_q) : DIFF_W'(dz_q);
  assign too_far = (mag_x > max_dist_q) || (mag_y > max_dist_q) || (mag_z > max_dist_q);

  logic signed [MUL_W-1:0] mul_a, mul_b;
  logic [CNT_W-1:0]        acc_sel;

  assign acc_sel = cnt_q - CNT_W'(1);

  always_comb begin
    case (cnt_q)
      CNT_W'(0): begin mul_a = MUL_W'(dx_q);    mul_b = MUL_W'(dx_q); end
      CNT_W'(1): begin mul_a = MUL_W'(dy_q);    mul_b = MUL_W'(dy_q); end
      CNT_W'(2): begin mul_a = MUL_W'(dz_q);    mul_b = MUL_W'(dz_q); end
      CNT_W'(3): begin mul_a = MUL_W'(fwd_x_q); mul_b = MUL_W'(dx_q); end
      CNT_W'(4): begin mul_a = MUL_W'(fwd_y_q); mul_b = MUL_W'(dy_q); end
      CNT_W'(5): begin mul_a = MUL_W'(fwd_z_q); mul_b = MUL_W'(dz_q); end
      CNT_W'(6): begin
        mul_a = $signed({1'b0, max_dist_q});
        mul_b = $signed({1'b0, max_dist_q});
      end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  logic                  dot_neg;
  logic                  skip_sq;
  logic                  div_sat;
  logic [ALIGN_W-1:0]    quot;

  assign dot_neg = dot_q[DOT_W-1];
  assign skip_sq = (sq_q == '0) || (sq_q > maxsq_q);
  assign div_sat = adot_q >= {root_q, {DIV_STEPS{1'b0}}};
  assign quot    = {1'b0, num_q};

  // shared compare and subtract step
  logic [STEP_W-1:0] step_cand, step_sub, step_diff;
  logic              step_ge;

  always_comb begin
    if (state_q == ST_DIV) begin
      step_cand = STEP_W'({rem_q[REM_W-2:0], num_q[DIV_STEPS-1]});
      step_sub  = STEP_W'(root_q);
    end else begin
      step_cand = STEP_W'({rem_q, sh_q[MAXSQ_W-1 -: 2]});
      step_sub  = STEP_W'({root_q, 2'b01});
    end
  end

  vcbts_sub_step u_step (
    .cand_i (step_cand),
    .sub_i  (step_sub),
    .ge_o   (step_ge),
    .diff_o (step_diff)
  );

  logic out_free;
  logic better;

  assign out_free = !m_valid_q || m_axis_tready;
  assign better   = (align_q >= min_align_q) &&
                    (!have_best_q || (align_q > kept_align_q) ||
                     ((align_q == kept_align_q) && (root_q < kept_dist_q)));

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (in_acc) state_d = go ? ST_RANGE : ST_FINISH;
      ST_RANGE:  state_d = too_far ? ST_FINISH : ST_MUL;
      ST_MUL:    if (cnt_q == CNT_W'(MUL_STEPS)) state_d = ST_CHECK;
      ST_CHECK:  state_d = skip_sq ? ST_FINISH : ST_SQRT;
      ST_SQRT:   if (cnt_q == CNT_W'(SQRT_STEPS - 1)) state_d = ST_DIVCHK;
      ST_DIVCHK: state_d = div_sat ? ST_DECIDE : ST_DIV;
      ST_DIV:    if (cnt_q == CNT_W'(DIV_STEPS - 1)) state_d = ST_ALIGN;
      ST_ALIGN:  state_d = ST_DECIDE;
      ST_DECIDE: state_d = ST_FINISH;
      ST_FINISH: if (!last_q || out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl = '0;
    case (state_q)
      ST_IDLE:   ctl.in_ready = 1'b1;
      ST_DECIDE: ctl.keep_upd = better;
      ST_FINISH: ctl.out_load = last_q && out_free;
      default:   ctl = '0;
    endcase
  end

  assign s_axis_tready = ctl.in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_acc) last_q <= s_axis_tlast;
      case (state_q)
        ST_RANGE, ST_CHECK, ST_DIVCHK: cnt_q <= '0;
        ST_MUL, ST_SQRT, ST_DIV:       cnt_q <= cnt_q + CNT_W'(1);
        default: ;
      endcase
    end
  end

  // payload datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          id_q <= s_axis_tdata[ID_BITS-1:0];
          dx_q <= DIFF_W'(cand_x) - DIFF_W'(origin_x_q);
          dy_q <= DIFF_W'(cand_y) - DIFF_W'(origin_y_q);
          dz_q <= DIFF_W'(cand_z) - DIFF_W'(origin_z_q);
        end
      end
      ST_RANGE: begin
        sq_q  <= '0;
        dot_q <= '0;
      end
      ST_MUL: begin
        prod_q <= mul_a * mul_b;
        // accumulate the product registered in the previous cycle
        if (cnt_q != '0) begin
          case (acc_sel)
            CNT_W'(0), CNT_W'(1), CNT_W'(2):
              sq_q <= sq_q + SQ_W'($unsigned(prod_q));
            CNT_W'(3), CNT_W'(4), CNT_W'(5):
              dot_q <= dot_q + DOT_W'(prod_q);
            default: maxsq_q <= prod_q[MAXSQ_W-1:0];
          endcase
        end
      end
      ST_CHECK: begin
        adot_q <= dot_neg ? ADOT_W'(-dot_q) : ADOT_W'(dot_q);
        sh_q   <= sq_q[MAXSQ_W-1:0];
        rem_q  <= '0;
        root_q <= '0;
      end
      ST_SQRT: begin
        sh_q  <= {sh_q[MAXSQ_W-3:0], 2'b00};
        rem_q <= step_diff[REM_W-1:0];
        root_q <= {root_q[DIST_W-2:0], step_ge};
      end
      ST_DIVCHK: begin
        rem_q  <= REM_W'(adot_q >> DIV_STEPS);
        num_q  <= adot_q[DIV_STEPS-1:0];
        align_q <= dot_neg ? ALIGN_MIN : ALIGN_MAX;
      end
      ST_DIV: begin
        rem_q <= step_diff[REM_W-1:0];
        num_q <= {num_q[DIV_STEPS-2:0], step_ge};
      end
      ST_ALIGN: begin
        align_q <= dot_neg ? $signed(ALIGN_W'(-quot)) : $signed(quot);
      end
      default: ;
    endcase
  end

  // kept candidate and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_best_q  <= 1'b0;
      kept_id_q    <= '0;
      kept_align_q <= '0;
      kept_dist_q  <= '0;
      m_valid_q    <= 1'b0;
      m_found_q    <= 1'b0;
      m_id_q       <= '0;
      m_align_q    <= '0;
      m_dist_q     <= '0;
    end else begin
      if (ctl.keep_upd) begin
        have_best_q  <= 1'b1;
        kept_id_q    <= id_q;
        kept_align_q <= align_q;
        kept_dist_q  <= root_q;
      end
      if (ctl.out_load) begin
        m_valid_q    <= 1'b1;
        m_found_q    <= have_best_q;
        m_id_q       <= kept_id_q;
        m_align_q    <= kept_align_q;
        m_dist_q     <= kept_dist_q;
        // start a new scan
        have_best_q  <= 1'b0;
        kept_id_q    <= '0;
        kept_align_q <= '0;
        kept_dist_q  <= '0;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_found_q;
  assign m_axis_tdata  = TDATA_OUT_W'({m_dist_q, m_align_q, m_id_q});

  // ---------------------------------------------------------------- assertions
  a_rise_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> $past(state_q == ST_FINISH && last_q))
    else $error("result raised outside the end of a scan");

  a_scan_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.out_load |=> !have_best_q && kept_dist_q == '0)
    else $error("kept candidate survived the end of a scan");

  a_kept_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    have_best_q |-> kept_dist_q != '0)
    else $error("kept candidate at zero distance");

  a_sqrt_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SQRT |-> cnt_q < CNT_W'(SQRT_STEPS))
    else $error("square root step count overran");

  a_busy_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !s_axis_tready)
    else $error("input ready while a candidate is in work");

endmodule
